FILE: rtl/pmap_pkg.sv
// Shared types for the partitioned LRU block mapper.
package pmap_pkg;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_FILL = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic stamp;
    logic load;
    logic halve;
  } cell_ctl_t;

  localparam int unsigned OUT_SLOT_W = 3;

endpackage

FILE: rtl/pmap_cell.sv
// One mapper slot: tag and age storage with hit and victim chain stages.
module pmap_cell #(
  parameter int unsigned BLK_W      = 32,
  parameter int unsigned AGE_W      = 16,
  parameter int unsigned IDX_W      = 3,
  parameter int unsigned SLOT_INDEX = 0,
  parameter bit          POOL_START = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 active,
  input  logic [BLK_W-1:0]     blk,
  input  pmap_pkg::cell_ctl_t  ctl,
  input  logic [AGE_W-1:0]     stamp_age,
  input  logic                 hit_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  input  logic [AGE_W-1:0]     min_age_i,
  input  logic [IDX_W-1:0]     min_idx_i,
  input  logic [BLK_W-1:0]     min_tag_i,
  output logic [AGE_W-1:0]     min_age_o,
  output logic [IDX_W-1:0]     min_idx_o,
  output logic [BLK_W-1:0]     min_tag_o
);
  import pmap_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_INDEX);
  localparam logic [BLK_W-1:0] MY_TAG = BLK_W'(SLOT_INDEX);

  logic [BLK_W-1:0] tag_r, tag_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             match;
  logic             take_min;
  logic [AGE_W-1:0] age_base;

  assign match     = active && (tag_r == blk);
  assign hit_o     = hit_i || match;
  assign hit_idx_o = (!hit_i && match) ? MY_IDX : hit_idx_i;

  assign take_min  = POOL_START || (age_r < min_age_i);
  assign min_age_o = take_min ? age_r : min_age_i;
  assign min_idx_o = take_min ? MY_IDX : min_idx_i;
  assign min_tag_o = take_min ? tag_r : min_tag_i;

  always_comb begin
    age_base = ctl.stamp ? stamp_age : age_r;
    age_nxt  = (ctl.halve && active) ? (age_base >> 1) : age_base;
    tag_nxt  = ctl.load ? blk : tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= MY_TAG;
      age_r <= '0;
    end else begin
      tag_r <= tag_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

FILE: rtl/partitioned_lru_block_mapper.sv
// Top level of the partitioned LRU block mapper: a row of slot cells and the result register.
//
// Usage:
//   in_*  : request channel (valid/ready), one request per block number lookup.
//   out_* : result channel (valid/ready), exactly one result per request.
//   cfg_* : cfg_we writes cfg_wdata into the second-pool enable; write only when idle.
// Each slot cell compares its tag in parallel; the hit priority and the per-pool
// oldest-slot search ripple along the row of cells within the same cycle, and the
// chosen cell is stamped (and all active ages halved on clock saturation) at the
// accepting edge.
// The result is registered: out_valid rises in the cycle after a request is accepted.
// Throughput: one request per cycle unless a held result drops in_ready; the cell row updates at each accepting edge.
// A request is taken while a result waits as long as out_ready is high in that cycle;
// with out_ready low and a result held, in_ready drops and the result holds.
// Reset: slot i holds tag i with age zero, age clock zero, second pool disabled,
// no result pending.
module partitioned_lru_block_mapper #(
  parameter int unsigned POOL_SLOTS  = 4,
  parameter int unsigned AGE_WIDTH   = 16,
  parameter int unsigned BLOCK_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_block_number,
  input  logic        in_pool_select,
  input  logic        in_remap_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [pmap_pkg::OUT_SLOT_W-1:0] out_slot_index,
  output logic [31:0] out_evicted_block,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import pmap_pkg::*;

  localparam int unsigned NUM_SLOTS = 2 * POOL_SLOTS;
  localparam int unsigned IDX_W     = $clog2(NUM_SLOTS);
  localparam logic [AGE_WIDTH-1:0] AGE_MAX  = {AGE_WIDTH{1'b1}};
  localparam logic [AGE_WIDTH-1:0] AGE_HALF = AGE_MAX >> 1;

  logic                   en_r;
  logic [AGE_WIDTH-1:0]   clock_r, clock_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                status_r, status_nxt;
  logic [OUT_SLOT_W-1:0]  slot_r, slot_nxt;
  logic [31:0]            evicted_r, evicted_nxt;

  logic                   accept;
  logic [BLOCK_WIDTH-1:0] blk;
  logic                   hit, fail, fill, do_stamp, halve;
  logic [IDX_W-1:0]       victim, sel;
  logic [BLOCK_WIDTH-1:0] victim_tag;
  logic [IDX_W+OUT_SLOT_W-1:0] sel_ext;

  logic                   hit_c     [NUM_SLOTS+1];
  logic [IDX_W-1:0]       hit_idx_c [NUM_SLOTS+1];
  logic [AGE_WIDTH-1:0]   min_age_c [NUM_SLOTS+1];
  logic [IDX_W-1:0]       min_idx_c [NUM_SLOTS+1];
  logic [BLOCK_WIDTH-1:0] min_tag_c [NUM_SLOTS+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign blk      = in_block_number[BLOCK_WIDTH-1:0];

  assign hit_c[0]     = 1'b0;
  assign hit_idx_c[0] = '0;
  assign min_age_c[0] = '0;
  assign min_idx_c[0] = '0;
  assign min_tag_c[0] = '0;

  generate
    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      cell_ctl_t ctl;
      logic      active;

      assign active    = (i < POOL_SLOTS) || en_r;
      assign ctl.stamp = accept && do_stamp && (sel == IDX_W'(i));
      assign ctl.load  = accept && fill && (victim == IDX_W'(i));
      assign ctl.halve = accept && halve;

      pmap_cell #(
        .BLK_W      (BLOCK_WIDTH),
        .AGE_W      (AGE_WIDTH),
        .IDX_W      (IDX_W),
        .SLOT_INDEX (i),
        .POOL_START ((i % POOL_SLOTS) == 0)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .active    (active),
        .blk       (blk),
        .ctl       (ctl),
        .stamp_age (clock_r),
        .hit_i     (hit_c[i]),
        .hit_idx_i (hit_idx_c[i]),
        .hit_o     (hit_c[i+1]),
        .hit_idx_o (hit_idx_c[i+1]),
        .min_age_i (min_age_c[i]),
        .min_idx_i (min_idx_c[i]),
        .min_tag_i (min_tag_c[i]),
        .min_age_o (min_age_c[i+1]),
        .min_idx_o (min_idx_c[i+1]),
        .min_tag_o (min_tag_c[i+1])
      );
    end
  endgenerate

  always_comb begin
    hit        = hit_c[NUM_SLOTS];
    fail       = !hit && ((in_pool_select && !en_r) || !in_remap_ok);
    fill       = !hit && !fail;
    do_stamp   = hit || fill;
    halve      = do_stamp && (clock_r == AGE_MAX);
    victim     = in_pool_select ? min_idx_c[NUM_SLOTS] : min_idx_c[POOL_SLOTS];
    victim_tag = in_pool_select ? min_tag_c[NUM_SLOTS] : min_tag_c[POOL_SLOTS];
    sel        = hit ? hit_idx_c[NUM_SLOTS] : victim;
    sel_ext    = {{OUT_SLOT_W{1'b0}}, sel};

    clock_nxt     = clock_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    evicted_nxt   = evicted_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (do_stamp) begin
        clock_nxt = halve ? AGE_HALF : clock_r + 1'b1;
      end
      if (hit) begin
        status_nxt  = ST_HIT;
        slot_nxt    = sel_ext[OUT_SLOT_W-1:0];
        evicted_nxt = '0;
      end else if (fill) begin
        status_nxt  = ST_FILL;
        slot_nxt    = sel_ext[OUT_SLOT_W-1:0];
        evicted_nxt = 32'(victim_tag);
      end else begin
        status_nxt  = ST_FAIL;
        slot_nxt    = '0;
        evicted_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_HIT;
    end else begin
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    evicted_r <= evicted_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_slot_index    = slot_r;
  assign out_evicted_block = evicted_r;

  a_halve_resets_clock: assert property (@(posedge clk) disable iff (!rst_n)
    accept && halve |=> clock_r == AGE_HALF)
    else $error("age clock not restarted at half range");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_HIT |-> evicted_r == '0)
    else $error("hit result carries an evicted block");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_FAIL |-> slot_r == '0 && evicted_r == '0)
    else $error("failed result carries slot or evicted block");

  a_fail_keeps_clock: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fail |=> $stable(clock_r))
    else $error("failed request changed the age clock");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for partitioned_lru_block_mapper: directed table and random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmap_pkg::*;

  localparam int POOL_SLOTS = 4;
  localparam int NUM_SLOTS = 2 * POOL_SLOTS;
  localparam int RANDOM_REQUESTS = 1150;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot;
    logic [31:0] evicted;
  } map_result_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] blk;
    logic        pool;
    logic        remap;
    logic        typed;
    status_t     status;
    logic [2:0]  slot;
    logic [31:0] evicted;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_block_number = '0;
  logic        in_pool_select = 1'b0;
  logic        in_remap_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [OUT_SLOT_W-1:0] out_slot_index;
  logic [31:0] out_evicted_block;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  logic [31:0] slot_tag_q [NUM_SLOTS];
  logic [15:0] slot_age_q [NUM_SLOTS];
  logic [15:0] age_clock_q;
  logic        pool2_on;

  map_result_t pending_mappings[$];
  logic [31:0] hot_blocks [12];
  bit          stall_on = 1'b0;
  int          mismatches = 0;
  int          requests_sent = 0;
  int          hit_count = 0;
  int          fill_count = 0;
  int          fail_count = 0;
  int          halvings = 0;
  int          cfg_writes = 0;
  int          cycle_count = 0;

  stim_row_t directed_rows [0:20] = '{
    '{ROW_REQ, 32'h0000_0000, 1'b0, 1'b1, 1'b1, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h0000_0003, 1'b0, 1'b0, 1'b1, ST_HIT,  3'd3, 32'h0},
    '{ROW_REQ, 32'h0000_0005, 1'b1, 1'b1, 1'b1, ST_FAIL, 3'd0, 32'h0},
    '{ROW_REQ, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, ST_FAIL, 3'd0, 32'h0},
    '{ROW_REQ, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h0000_0004, 1'b0, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h8000_0000, 1'b0, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h0000_0000, 1'b0, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_CFG, 32'h0000_0000, 1'b1, 1'b0, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h0000_0005, 1'b0, 1'b0, 1'b1, ST_HIT,  3'd5, 32'h0},
    '{ROW_REQ, 32'h0000_0007, 1'b1, 1'b0, 1'b1, ST_HIT,  3'd7, 32'h0},
    '{ROW_REQ, 32'h0000_0004, 1'b1, 1'b0, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'hA5A5_A5A5, 1'b1, 1'b0, 1'b1, ST_FAIL, 3'd0, 32'h0},
    '{ROW_REQ, 32'hA5A5_A5A5, 1'b1, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h5A5A_5A5A, 1'b1, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h5A5A_5A5A, 1'b0, 1'b1, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_CFG, 32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_HIT,  3'd0, 32'h0},
    '{ROW_REQ, 32'h5A5A_5A5A, 1'b0, 1'b0, 1'b1, ST_FAIL, 3'd0, 32'h0},
    '{ROW_REQ, 32'h5A5A_5A5A, 1'b1, 1'b1, 1'b1, ST_FAIL, 3'd0, 32'h0}
  };

  partitioned_lru_block_mapper u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_block_number  (in_block_number),
    .in_pool_select   (in_pool_select),
    .in_remap_ok      (in_remap_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_evicted_block(out_evicted_block),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_mappings.size());
      $display("** partitioned_lru_block_mapper: FAILED **");
      $finish;
    end
  end

  function automatic void stamp_age(int s);
    int i;
    slot_age_q[s] = age_clock_q;
    age_clock_q = age_clock_q + 16'd1;
    if (slot_age_q[s] == 16'hFFFF) begin
      for (i = 0; i < (pool2_on ? NUM_SLOTS : POOL_SLOTS); i++) begin
        slot_age_q[i] = slot_age_q[i] >> 1;
      end
      age_clock_q = 16'h7FFF;
      halvings++;
    end
  endfunction

  function automatic map_result_t map_lookup(logic [31:0] blk, logic pool, logic remap);
    map_result_t r;
    int i;
    int hit_slot;
    int first;
    int victim;
    r = '{ST_FAIL, 3'd0, 32'd0};
    hit_slot = -1;
    for (i = 0; i < (pool2_on ? NUM_SLOTS : POOL_SLOTS); i++) begin
      if (hit_slot < 0 && slot_tag_q[i] == blk) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      stamp_age(hit_slot);
      r.status = ST_HIT;
      r.slot = hit_slot[2:0];
      hit_count++;
    end else if ((pool && !pool2_on) || !remap) begin
      fail_count++;
    end else begin
      first = pool ? POOL_SLOTS : 0;
      victim = first;
      for (i = first + 1; i < first + POOL_SLOTS; i++) begin
        if (slot_age_q[i] < slot_age_q[victim]) victim = i;
      end
      r.status = ST_FILL;
      r.slot = victim[2:0];
      r.evicted = slot_tag_q[victim];
      stamp_age(victim);
      slot_tag_q[victim] = blk;
      fill_count++;
    end
    return r;
  endfunction

  task automatic issue_request(input logic [31:0] blk, input logic pool, input logic remap,
                               input logic typed, input map_result_t typed_result);
    int gap;
    map_result_t pred;
    gap = stall_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_block_number <= blk;
    in_pool_select <= pool;
    in_remap_ok <= remap;
    do @(posedge clk); while (!in_ready);
    pred = map_lookup(blk, pool, remap);
    pending_mappings.push_back(typed ? typed_result : pred);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_mappings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_pool_enable(input logic value);
    drain_results();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool2_on = value;
    cfg_writes++;
  endtask

  task automatic check_result();
    map_result_t want;
    if (pending_mappings.size() == 0) begin
      mismatches++;
      $display("%0t: result with no request outstanding: status=%0d slot=%0d evicted=%h",
               $time, out_status, out_slot_index, out_evicted_block);
    end else begin
      want = pending_mappings.pop_front();
      if (out_status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
      end
      if (out_slot_index !== want.slot) begin
        mismatches++;
        $display("%0t: slot_index expected %0d, got %0d", $time, want.slot, out_slot_index);
      end
      if (out_evicted_block !== want.evicted) begin
        mismatches++;
        $display("%0t: evicted_block expected %h, got %h", $time, want.evicted,
                 out_evicted_block);
      end
    end
  endtask

  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result();
    end
  end

  initial begin
    int i;
    int n;
    stim_row_t row;
    map_result_t typed_result;
    logic [31:0] blk;

    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_tag_q[i] = i;
      slot_age_q[i] = '0;
    end
    age_clock_q = '0;
    pool2_on = 1'b0;
    for (i = 0; i < 12; i++) begin
      hot_blocks[i] = (i < 4) ? $urandom_range(0, NUM_SLOTS - 1) : $urandom;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stall_on = 1'b1;
    for (i = 0; i < $size(directed_rows); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_pool_enable(row.pool);
      end else begin
        typed_result = '{row.status, row.slot, row.evicted};
        issue_request(row.blk, row.pool, row.remap, row.typed, typed_result);
      end
    end

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) stall_on = $urandom_range(0, 3) != 0;
      if (n % 150 == 149) write_pool_enable(~pool2_on);
      if (n == 600) drain_results();
      blk = ($urandom_range(0, 9) < 7) ? hot_blocks[$urandom_range(0, 11)] : $urandom;
      issue_request(blk, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0, 1'b0, '0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d hits, %0d fills, %0d failures.",
             requests_sent, hit_count, fill_count, fail_count);
    $display("Age clock saturated %0d times; pool enable written %0d times.",
             halvings, cfg_writes);
    if (mismatches == 0) begin
      $display("** partitioned_lru_block_mapper: PASSED **");
    end else begin
      $display("** partitioned_lru_block_mapper: FAILED **");
    end
    $finish;
  end

endmodule
